// ===== sv/lgps_pkg.sv =====
`default_nettype none

package lgps_pkg;

    // Legs served by the block, and the legs the packed fields have room for.
    localparam int LEG_COUNT    = 4;
    localparam int FIELD_LEGS   = 4;
    localparam int MAX_SEGMENTS = 32;
    localparam int ROW_LIMIT    = 32;
    localparam int SEG_LIMIT    = (MAX_SEGMENTS < ROW_LIMIT) ? MAX_SEGMENTS : ROW_LIMIT;

    localparam int SEG_W      = 6;   // segment count, holds SEG_LIMIT itself
    localparam int IDX_W      = 5;   // segment or row index
    localparam int TICK_W     = 10;
    localparam int PER_W      = 15;  // gait period in ticks, up to 32 * 1023
    localparam int Q_W        = 16;  // one Q1.15 progress lane
    localparam int ITER_W     = 32;
    localparam int STIME_W    = 32;
    localparam int TIME_W     = 38;
    localparam int DIV_W      = 16;  // divisor and remainder of the serial divider
    localparam int NB_W       = 6;   // divider step count, holds ITER_W
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PACK_W     = 24;
    localparam int LANE_W     = 6;   // one packed offset or duration

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEGMENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEG_OFFSETS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEG_DURATIONS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_TIME      = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LAUNCH,
        ST_WAIT,
        ST_ROWS
    } t_state;

    typedef enum logic [1:0] {
        JOB_MODP,
        JOB_CUR,
        JOB_OFF,
        JOB_FRAC
    } t_job;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem_init;
        logic [ITER_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
        logic [NB_W-1:0]   nbits;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [ITER_W-1:0] quot;
        logic [DIV_W-1:0]  rem;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [SEG_W-1:0] n;
        logic [IDX_W-1:0] cur;
    } t_row_cmd;

    typedef struct packed {
        logic active;
        logic done;
    } t_row_sts;

    typedef struct packed {
        logic [FIELD_LEGS-1:0][IDX_W-1:0] off;
        logic [FIELD_LEGS-1:0][SEG_W-1:0] dur;
        logic [IDX_W-1:0]                 cur;
        logic [FIELD_LEGS*Q_W-1:0]        stp;
        logic [FIELD_LEGS*Q_W-1:0]        swp;
        logic [TIME_W-1:0]                st_time;
        logic [TIME_W-1:0]                sw_time;
    } t_row_data;

endpackage

`default_nettype wire

// ===== sv/lgps_if.sv =====
`default_nettype none

interface lgps_in_if;
    logic                        valid;
    logic                        ready;
    logic [lgps_pkg::ITER_W-1:0] iteration_count;

    modport source(output valid, output iteration_count, input ready);
    modport sink(input valid, input iteration_count, output ready);
endinterface

interface lgps_out_if;
    logic                                             valid;
    logic                                             ready;
    logic [lgps_pkg::IDX_W-1:0]                       row_index;
    logic [lgps_pkg::FIELD_LEGS-1:0]                  row_contacts;
    logic                                             last_row;
    logic [lgps_pkg::IDX_W-1:0]                       current_segment;
    logic [lgps_pkg::FIELD_LEGS*lgps_pkg::Q_W-1:0]    stance_progress;
    logic [lgps_pkg::FIELD_LEGS*lgps_pkg::Q_W-1:0]    swing_progress;
    logic [lgps_pkg::TIME_W-1:0]                      stance_time;
    logic [lgps_pkg::TIME_W-1:0]                      swing_time;

    modport source(output valid, output row_index, output row_contacts, output last_row,
                   output current_segment, output stance_progress, output swing_progress,
                   output stance_time, output swing_time, input ready);
    modport sink(input valid, input row_index, input row_contacts, input last_row,
                 input current_segment, input stance_progress, input swing_progress,
                 input stance_time, input swing_time, output ready);
endinterface

interface lgps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lgps_pkg::CFG_IDX_W-1:0]  index;
    logic [lgps_pkg::CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/legged_gait_phase_scheduler.sv =====
`default_nettype none

// Four-leg gait phase scheduler. Each input transaction carries an iteration
// count; the block places it in the gait cycle (N segments of T ticks, with N
// clamped to 1..32 and T to 1..1023), and then emits N output transactions,
// one contact-mask row per horizon segment starting with the segment after
// the current one. Every row repeats the current segment, the four Q1.15
// stance and swing progress lanes (0 outside the window or for an empty
// window, 0x8000 at the window end) and the stance and swing times of leg 0.
// All divisions go through one shared bit-serial divider, in turn: the period
// remainder, the segment, each leg offset and each progress lane, with setup
// around each division. Then the rows go out as the sink's ready allows.
// A new item is taken once the last row has gone out.
// Configuration writes are always accepted and must come while idle.
module legged_gait_phase_scheduler (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lgps_cfg_if.sink    i_cfg,
    lgps_in_if.sink     i_in,
    lgps_out_if.source  o_out
);

    localparam int FRAC_JOBS = 2 * lgps_pkg::FIELD_LEGS;

    // configuration registers
    logic [lgps_pkg::SEG_W-1:0]   r_cfg_segs;
    logic [lgps_pkg::TICK_W-1:0]  r_cfg_ticks;
    logic [lgps_pkg::PACK_W-1:0]  r_cfg_offs;
    logic [lgps_pkg::PACK_W-1:0]  r_cfg_durs;
    logic [lgps_pkg::STIME_W-1:0] r_cfg_stime;

    // control
    lgps_pkg::t_state r_state;
    lgps_pkg::t_state n_state;
    lgps_pkg::t_job   r_job;
    logic [2:0]       r_idx;

    // per-item working values
    logic [lgps_pkg::ITER_W-1:0] r_iter;
    logic [lgps_pkg::SEG_W-1:0]  r_n;
    logic [lgps_pkg::TICK_W-1:0] r_t;
    logic [lgps_pkg::PER_W-1:0]  r_period;
    logic [lgps_pkg::PER_W-1:0]  r_p;
    logic [lgps_pkg::IDX_W-1:0]  r_cur;
    logic [lgps_pkg::IDX_W-1:0]  r_off [lgps_pkg::FIELD_LEGS];
    logic [lgps_pkg::SEG_W-1:0]  r_dur [lgps_pkg::FIELD_LEGS];
    logic [lgps_pkg::PER_W-1:0]  r_base;
    logic [lgps_pkg::PER_W-1:0]  r_len;
    logic                        r_special;
    logic [lgps_pkg::Q_W-1:0]    r_spec_val;
    logic [lgps_pkg::Q_W-1:0]    r_stp [lgps_pkg::FIELD_LEGS];
    logic [lgps_pkg::Q_W-1:0]    r_swp [lgps_pkg::FIELD_LEGS];
    logic [lgps_pkg::TIME_W-1:0] r_st_time;
    logic [lgps_pkg::TIME_W-1:0] r_sw_time;

    // combinational helpers
    logic                        in_fire;
    logic                        cfg_fire;
    logic [lgps_pkg::SEG_W-1:0]  n_n;
    logic [lgps_pkg::TICK_W-1:0] n_t;
    logic [lgps_pkg::SEG_W-1:0]  raw_dur [lgps_pkg::FIELD_LEGS];
    logic [lgps_pkg::SEG_W-1:0]  raw_off;
    logic [1:0]                  leg;
    logic                        swing;
    logic [lgps_pkg::SEG_W-1:0]  sw_start;
    logic [lgps_pkg::IDX_W-1:0]  start_seg;
    logic [lgps_pkg::SEG_W-1:0]  len_seg;
    logic [lgps_pkg::PER_W:0]    rr_wide;
    logic [lgps_pkg::PER_W-1:0]  rr;
    logic [lgps_pkg::Q_W-1:0]    frac_val;
    logic                        last_job;
    logic                        div_start;
    logic                        row_start;
    logic                        in_ready;

    lgps_pkg::t_div_req  div_req;
    lgps_pkg::t_div_rsp  div_rsp;
    lgps_pkg::t_row_cmd  row_cmd;
    lgps_pkg::t_row_sts  row_sts;
    lgps_pkg::t_row_data row_data;

    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_segs  <= lgps_pkg::SEG_W'(10);
            r_cfg_ticks <= lgps_pkg::TICK_W'(1);
            r_cfg_offs  <= '0;
            r_cfg_durs  <= '0;
            r_cfg_stime <= '0;
        end else if (cfg_fire) begin
            case (i_cfg.index)
                lgps_pkg::CFG_SEGMENT_COUNT: begin
                    r_cfg_segs <= i_cfg.data[lgps_pkg::SEG_W-1:0];
                end
                lgps_pkg::CFG_TICKS_PER_SEGMENT: begin
                    r_cfg_ticks <= i_cfg.data[lgps_pkg::TICK_W-1:0];
                end
                lgps_pkg::CFG_LEG_OFFSETS: begin
                    r_cfg_offs <= i_cfg.data[lgps_pkg::PACK_W-1:0];
                end
                lgps_pkg::CFG_LEG_DURATIONS: begin
                    r_cfg_durs <= i_cfg.data[lgps_pkg::PACK_W-1:0];
                end
                lgps_pkg::CFG_SEGMENT_TIME: begin
                    r_cfg_stime <= i_cfg.data[lgps_pkg::STIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Clamped settings, taken when an item arrives
    // ---------------------------------------------------------------------
    always_comb begin
        if (r_cfg_segs == '0) begin
            n_n = lgps_pkg::SEG_W'(1);
        end else if (r_cfg_segs > lgps_pkg::SEG_W'(lgps_pkg::SEG_LIMIT)) begin
            n_n = lgps_pkg::SEG_W'(lgps_pkg::SEG_LIMIT);
        end else begin
            n_n = r_cfg_segs;
        end
        n_t = (r_cfg_ticks == '0) ? lgps_pkg::TICK_W'(1) : r_cfg_ticks;
        for (int j = 0; j < lgps_pkg::FIELD_LEGS; j++) begin
            raw_dur[j] = r_cfg_durs[lgps_pkg::LANE_W*j +: lgps_pkg::LANE_W];
        end
    end

    // ---------------------------------------------------------------------
    // Per-job operands
    // ---------------------------------------------------------------------
    always_comb begin
        raw_off = r_cfg_offs[lgps_pkg::LANE_W*r_idx[1:0] +: lgps_pkg::LANE_W];
        leg     = r_idx[2:1];
        swing   = r_idx[0];

        // swing starts where stance ends, (off + dur) mod n
        sw_start = {1'b0, r_off[leg]} + r_dur[leg];
        if (sw_start >= r_n) begin
            sw_start = sw_start - r_n;
        end
        start_seg = swing ? sw_start[lgps_pkg::IDX_W-1:0] : r_off[leg];
        len_seg   = swing ? (r_n - r_dur[leg]) : r_dur[leg];

        // position within the window, (p - base) mod period
        if (r_p >= r_base) begin
            rr_wide = {1'b0, r_p} - {1'b0, r_base};
        end else begin
            rr_wide = {1'b0, r_p} + {1'b0, r_period} - {1'b0, r_base};
        end
        rr = rr_wide[lgps_pkg::PER_W-1:0];

        frac_val = r_special ? r_spec_val
                             : {1'b0, div_rsp.quot[lgps_pkg::Q_W-2:0]};
        last_job = (r_job == lgps_pkg::JOB_FRAC) && (r_idx == 3'(FRAC_JOBS - 1));
    end

    always_comb begin
        div_req.start    = div_start;
        div_req.rem_init = '0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.nbits    = '0;
        case (r_job)
            lgps_pkg::JOB_MODP: begin
                div_req.dividend = r_iter;
                div_req.divisor  = lgps_pkg::DIV_W'(r_period);
                div_req.nbits    = lgps_pkg::NB_W'(lgps_pkg::ITER_W);
            end
            lgps_pkg::JOB_CUR: begin
                div_req.dividend = {r_p, (lgps_pkg::ITER_W - lgps_pkg::PER_W)'(0)};
                div_req.divisor  = lgps_pkg::DIV_W'(r_t);
                div_req.nbits    = lgps_pkg::NB_W'(lgps_pkg::PER_W);
            end
            lgps_pkg::JOB_OFF: begin
                div_req.dividend = {raw_off, (lgps_pkg::ITER_W - lgps_pkg::LANE_W)'(0)};
                div_req.divisor  = lgps_pkg::DIV_W'(r_n);
                div_req.nbits    = lgps_pkg::NB_W'(lgps_pkg::LANE_W);
            end
            lgps_pkg::JOB_FRAC: begin
                // for r < len the quotient from rem = r is r * 2^15 / len; else r_spec_val is used
                div_req.rem_init = lgps_pkg::DIV_W'(rr);
                div_req.divisor  = lgps_pkg::DIV_W'(r_len);
                div_req.nbits    = lgps_pkg::NB_W'(lgps_pkg::Q_W - 1);
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgps_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = lgps_pkg::ST_PREP;
                end
            end
            lgps_pkg::ST_PREP: begin
                n_state = lgps_pkg::ST_LAUNCH;
            end
            lgps_pkg::ST_LAUNCH: begin
                n_state = lgps_pkg::ST_WAIT;
            end
            lgps_pkg::ST_WAIT: begin
                if (div_rsp.done) begin
                    n_state = last_job ? lgps_pkg::ST_ROWS : lgps_pkg::ST_PREP;
                end
            end
            lgps_pkg::ST_ROWS: begin
                if (row_sts.done) begin
                    n_state = lgps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lgps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        row_start = 1'b0;
        case (r_state)
            lgps_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            lgps_pkg::ST_LAUNCH: begin
                div_start = 1'b1;
            end
            lgps_pkg::ST_WAIT: begin
                row_start = div_rsp.done && last_job;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgps_pkg::ST_IDLE;
            r_job   <= lgps_pkg::JOB_MODP;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_job <= lgps_pkg::JOB_MODP;
                r_idx <= '0;
            end else if (r_state == lgps_pkg::ST_WAIT && div_rsp.done) begin
                case (r_job)
                    lgps_pkg::JOB_MODP: begin
                        r_job <= lgps_pkg::JOB_CUR;
                    end
                    lgps_pkg::JOB_CUR: begin
                        r_job <= lgps_pkg::JOB_OFF;
                        r_idx <= '0;
                    end
                    lgps_pkg::JOB_OFF: begin
                        if (r_idx == 3'(lgps_pkg::FIELD_LEGS - 1)) begin
                            r_job <= lgps_pkg::JOB_FRAC;
                            r_idx <= '0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    lgps_pkg::JOB_FRAC: begin
                        r_idx <= r_idx + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_iter   <= i_in.iteration_count;
            r_n      <= n_n;
            r_t      <= n_t;
            r_period <= lgps_pkg::PER_W'(n_n) * lgps_pkg::PER_W'(n_t);
            for (int j = 0; j < lgps_pkg::FIELD_LEGS; j++) begin
                r_dur[j] <= (raw_dur[j] > n_n) ? n_n : raw_dur[j];
            end
        end

        if (r_state == lgps_pkg::ST_PREP) begin
            r_base <= lgps_pkg::PER_W'(start_seg) * lgps_pkg::PER_W'(r_t);
            r_len  <= lgps_pkg::PER_W'(len_seg) * lgps_pkg::PER_W'(r_t);
            if (r_job == lgps_pkg::JOB_MODP) begin
                r_st_time <= lgps_pkg::TIME_W'(r_cfg_stime) * lgps_pkg::TIME_W'(r_dur[0]);
                r_sw_time <= lgps_pkg::TIME_W'(r_cfg_stime)
                             * lgps_pkg::TIME_W'(r_n - r_dur[0]);
            end
        end

        // empty window or outside it: 0; at the window end exactly 1.0
        if (r_state == lgps_pkg::ST_LAUNCH) begin
            r_special  <= (r_len == '0) || (rr >= r_len);
            r_spec_val <= ((r_len != '0) && (rr == r_len))
                          ? lgps_pkg::Q_W'(1 << (lgps_pkg::Q_W - 1)) : '0;
        end

        if (r_state == lgps_pkg::ST_WAIT && div_rsp.done) begin
            case (r_job)
                lgps_pkg::JOB_MODP: begin
                    r_p <= div_rsp.rem[lgps_pkg::PER_W-1:0];
                end
                lgps_pkg::JOB_CUR: begin
                    r_cur <= div_rsp.quot[lgps_pkg::IDX_W-1:0];
                end
                lgps_pkg::JOB_OFF: begin
                    r_off[r_idx[1:0]] <= div_rsp.rem[lgps_pkg::IDX_W-1:0];
                end
                lgps_pkg::JOB_FRAC: begin
                    if (swing) begin
                        r_swp[leg] <= frac_val;
                    end else begin
                        r_stp[leg] <= frac_val;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Row emitter
    // ---------------------------------------------------------------------
    always_comb begin
        row_cmd.start = row_start;
        row_cmd.n     = r_n;
        row_cmd.cur   = r_cur;

        row_data.cur     = r_cur;
        row_data.st_time = r_st_time;
        row_data.sw_time = r_sw_time;
        for (int j = 0; j < lgps_pkg::FIELD_LEGS; j++) begin
            row_data.off[j] = r_off[j];
            row_data.dur[j] = r_dur[j];
            row_data.stp[lgps_pkg::Q_W*j +: lgps_pkg::Q_W] =
                (j < lgps_pkg::LEG_COUNT) ? r_stp[j] : '0;
            row_data.swp[lgps_pkg::Q_W*j +: lgps_pkg::Q_W] =
                (j < lgps_pkg::LEG_COUNT) ? r_swp[j] : '0;
        end
    end

    lgps_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lgps_rows u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (row_cmd),
        .i_data  (row_data),
        .o_sts   (row_sts),
        .o_out   (o_out)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_no_input_while_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input taken while rows are pending");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == lgps_pkg::ST_WAIT))
        else $error("divider finished outside wait state");

    a_last_row_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_row) |-> ({1'b0, o_out.row_index} == (r_n - 1'b1)))
        else $error("last row flag on wrong row");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == lgps_pkg::ST_PREP) && (r_job == lgps_pkg::JOB_MODP))
        else $error("accepted item did not start the sequence");

endmodule

`default_nettype wire

// ===== sv/lgps_sdiv.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, dividend shifted in MSB first.
// The quotient collects in the low bits of the shift register.
module lgps_sdiv (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lgps_pkg::t_div_req i_req,
    output lgps_pkg::t_div_rsp      o_rsp
);

    logic [lgps_pkg::DIV_W-1:0]  r_rem;
    logic [lgps_pkg::DIV_W-1:0]  n_rem;
    logic [lgps_pkg::DIV_W-1:0]  r_div;
    logic [lgps_pkg::ITER_W-1:0] r_shift;
    logic [lgps_pkg::ITER_W-1:0] n_shift;
    logic [lgps_pkg::NB_W-1:0]   r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [lgps_pkg::DIV_W:0]    trial;
    logic [lgps_pkg::DIV_W:0]    diff;
    logic                        qbit;

    always_comb begin
        trial   = {r_rem, r_shift[lgps_pkg::ITER_W-1]};
        diff    = trial - {1'b0, r_div};
        qbit    = (trial >= {1'b0, r_div});
        n_rem   = qbit ? diff[lgps_pkg::DIV_W-1:0] : trial[lgps_pkg::DIV_W-1:0];
        n_shift = {r_shift[lgps_pkg::ITER_W-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == lgps_pkg::NB_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem   <= i_req.rem_init;
            r_shift <= i_req.dividend;
            r_div   <= i_req.divisor;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= n_shift;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_shift;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

// ===== sv/lgps_rows.sv =====
`default_nettype none

// Contact-mask row emitter: one row per output transaction, walking the
// segments of the horizon from the one after the current segment.
module lgps_rows (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lgps_pkg::t_row_cmd  i_cmd,
    input  wire lgps_pkg::t_row_data i_data,
    output lgps_pkg::t_row_sts       o_sts,
    lgps_out_if.source               o_out
);

    logic                             r_active;
    logic                             r_done;
    logic [lgps_pkg::IDX_W-1:0]       r_idx;
    logic [lgps_pkg::IDX_W-1:0]       r_seg;
    logic [lgps_pkg::SEG_W-1:0]       r_n;
    logic [lgps_pkg::SEG_W-1:0]       first_seg;
    logic [lgps_pkg::SEG_W-1:0]       next_seg;
    logic [lgps_pkg::SEG_W-1:0]       prog [lgps_pkg::FIELD_LEGS];
    logic [lgps_pkg::FIELD_LEGS-1:0]  contacts;
    logic                             last;
    logic                             fire;

    always_comb begin
        first_seg = {1'b0, i_cmd.cur} + 1'b1;
        if (first_seg == i_cmd.n) begin
            first_seg = '0;
        end
        next_seg = {1'b0, r_seg} + 1'b1;
        if (next_seg == r_n) begin
            next_seg = '0;
        end
    end

    // Leg j is in stance when (seg - off) mod n falls below its duration.
    always_comb begin
        for (int j = 0; j < lgps_pkg::FIELD_LEGS; j++) begin
            if (r_seg >= i_data.off[j]) begin
                prog[j] = {1'b0, r_seg} - {1'b0, i_data.off[j]};
            end else begin
                prog[j] = {1'b0, r_seg} + r_n - {1'b0, i_data.off[j]};
            end
            contacts[j] = (j < lgps_pkg::LEG_COUNT) && (prog[j] < i_data.dur[j]);
        end
    end

    assign last = ({1'b0, r_idx} == (r_n - 1'b1));
    assign fire = r_active && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (fire) begin
                if (last) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n   <= i_cmd.n;
            r_seg <= first_seg[lgps_pkg::IDX_W-1:0];
        end else if (fire) begin
            r_seg <= next_seg[lgps_pkg::IDX_W-1:0];
        end
    end

    assign o_sts.active = r_active;
    assign o_sts.done   = r_done;

    assign o_out.valid           = r_active;
    assign o_out.row_index       = r_idx;
    assign o_out.row_contacts    = contacts;
    assign o_out.last_row        = last;
    assign o_out.current_segment = i_data.cur;
    assign o_out.stance_progress = i_data.stp;
    assign o_out.swing_progress  = i_data.swp;
    assign o_out.stance_time     = i_data.st_time;
    assign o_out.swing_time      = i_data.sw_time;

endmodule

`default_nettype wire

// ===== test/gait_row_checker.sv =====
`default_nettype none

// Watches the three channels of the gait scheduler. It keeps its own copy of
// the registers, works out every contact-mask row that an accepted iteration
// count must produce, and compares output transactions against them in order.
module gait_row_checker
    import lgps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lgps_cfg_if       i_cfg,
    lgps_in_if        i_in,
    lgps_out_if       i_out,
    output int        o_fail_count,
    output int        o_rows_outstanding
);

    typedef struct {
        logic [IDX_W-1:0]          row_index;
        logic [FIELD_LEGS-1:0]     row_contacts;
        logic                      last_row;
        logic [IDX_W-1:0]          current_segment;
        logic [FIELD_LEGS*Q_W-1:0] stance_progress;
        logic [FIELD_LEGS*Q_W-1:0] swing_progress;
        logic [TIME_W-1:0]         stance_time;
        logic [TIME_W-1:0]         swing_time;
    } t_gait_row;

    t_gait_row expected_rows[$];

    logic [SEG_W-1:0]   seg_count_r;
    logic [TICK_W-1:0]  ticks_r;
    logic [PACK_W-1:0]  offsets_r;
    logic [PACK_W-1:0]  durations_r;
    logic [STIME_W-1:0] seg_time_r;

    int fail_total = 0;
    int rows_left  = 0;

    assign o_fail_count       = fail_total;
    assign o_rows_outstanding = rows_left;

    // Q1.15 share of a window; empty window or outside it gives 0
    function automatic logic [Q_W-1:0] q15_fraction(input longint unsigned r,
                                                     input longint unsigned len);
        if (len == 0 || r > len) return '0;
        return Q_W'((r << 15) / len);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    task automatic predict_rows(input logic [ITER_W-1:0] iter);
        longint unsigned n, t, it, period, p, cur, r_st, r_sw, seg, lag;
        longint unsigned off [FIELD_LEGS];
        longint unsigned dur [FIELD_LEGS];
        logic [FIELD_LEGS*Q_W-1:0] stp, swp;
        logic [FIELD_LEGS-1:0]     mask;
        t_gait_row                 row;

        n = seg_count_r;
        if (n == 0) n = 1;
        if (n > SEG_LIMIT) n = SEG_LIMIT;
        t = ticks_r;
        if (t == 0) t = 1;

        for (int j = 0; j < FIELD_LEGS; j++) begin
            off[j] = offsets_r[LANE_W*j +: LANE_W] % n;
            dur[j] = durations_r[LANE_W*j +: LANE_W];
            if (dur[j] > n) dur[j] = n;
        end

        it     = iter;
        period = n * t;
        p      = it % period;
        cur    = (it / t) % n;

        stp = '0;
        swp = '0;
        for (int j = 0; j < FIELD_LEGS; j++) begin
            if (j < LEG_COUNT) begin
                r_st = (p + period - off[j] * t) % period;
                r_sw = (p + period - ((off[j] + dur[j]) % n) * t) % period;
                stp[Q_W*j +: Q_W] = q15_fraction(r_st, dur[j] * t);
                swp[Q_W*j +: Q_W] = q15_fraction(r_sw, (n - dur[j]) * t);
            end
        end

        row.current_segment = IDX_W'(cur);
        row.stance_progress = stp;
        row.swing_progress  = swp;
        row.stance_time     = TIME_W'(seg_time_r * dur[0]);
        row.swing_time      = TIME_W'(seg_time_r * (n - dur[0]));

        for (int i = 0; i < n; i++) begin
            seg  = (i + cur + 1) % n;
            mask = '0;
            for (int j = 0; j < FIELD_LEGS; j++) begin
                lag = (seg + n - off[j]) % n;
                if (j < LEG_COUNT && lag < dur[j]) mask[j] = 1'b1;
            end
            row.row_index    = IDX_W'(i);
            row.row_contacts = mask;
            row.last_row     = (i == n - 1);
            expected_rows.push_back(row);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_gait_row want;
        if (!i_rst_n) begin
            seg_count_r = SEG_W'(10);
            ticks_r     = TICK_W'(1);
            offsets_r   = '0;
            durations_r = '0;
            seg_time_r  = '0;
            expected_rows.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_SEGMENT_COUNT:     seg_count_r = i_cfg.data[SEG_W-1:0];
                    CFG_TICKS_PER_SEGMENT: ticks_r     = i_cfg.data[TICK_W-1:0];
                    CFG_LEG_OFFSETS:       offsets_r   = i_cfg.data[PACK_W-1:0];
                    CFG_LEG_DURATIONS:     durations_r = i_cfg.data[PACK_W-1:0];
                    CFG_SEGMENT_TIME:      seg_time_r  = i_cfg.data[STIME_W-1:0];
                    default: ;
                endcase
            end
            // rows of an earlier item leave before a new item can be taken
            if (i_out.valid && i_out.ready) begin
                if (expected_rows.size() == 0) begin
                    $error("row_index: expected no transaction, got 0x%0h", i_out.row_index);
                    fail_total++;
                end else begin
                    want = expected_rows.pop_front();
                    check_field("row_index", want.row_index, i_out.row_index);
                    check_field("row_contacts", want.row_contacts, i_out.row_contacts);
                    check_field("last_row", want.last_row, i_out.last_row);
                    check_field("current_segment", want.current_segment,
                                i_out.current_segment);
                    check_field("stance_progress", want.stance_progress,
                                i_out.stance_progress);
                    check_field("swing_progress", want.swing_progress, i_out.swing_progress);
                    check_field("stance_time", want.stance_time, i_out.stance_time);
                    check_field("swing_time", want.swing_time, i_out.swing_time);
                end
            end
            if (i_in.valid && i_in.ready) predict_rows(i_in.iteration_count);
        end
        rows_left = expected_rows.size();
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

// Top of the gait scheduler test. It makes the clock and the single reset,
// drives the register port and the iteration channel, paces the row sink,
// and gives the verdict. All prediction and comparison lives in the checker.
//
// Inputs change on the falling edge; the handshakes are judged on the
// rising edge, so nothing depends on event order inside a time step.
module tb;
    import lgps_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    // Slowest legal run: ~450 items, each with its arithmetic and up to 32 rows,
    // every row stalled by the sink at times, plus sender gaps; the limit is far above it.
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SINK_HOLD     = 600;   // long sink back-pressure stretch
    localparam int TAIL_CYCLES   = 600;   // quiet time after the last rows drain
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic hold_sink = 1'b0;   // raised by the sender, cleared by the sink pacer
    int   cycle_count = 0;
    int   fail_count;
    int   rows_outstanding;

    lgps_cfg_if cfg_ch ();
    lgps_in_if  in_ch ();
    lgps_out_if out_ch ();

    legged_gait_phase_scheduler dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gait_row_checker mon (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg              (cfg_ch),
        .i_in               (in_ch),
        .i_out              (out_ch),
        .o_fail_count       (fail_count),
        .o_rows_outstanding (rows_outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("legged_gait_phase_scheduler test failed");
        $finish;
    end

    // Four 6-bit lanes, leg 0 in the low bits.
    function automatic logic [PACK_W-1:0] pack_lanes(input logic [LANE_W-1:0] l0,
                                                     input logic [LANE_W-1:0] l1,
                                                     input logic [LANE_W-1:0] l2,
                                                     input logic [LANE_W-1:0] l3);
        return {l3, l2, l1, l0};
    endfunction

    // Mostly a lane inside the cycle, sometimes any 6-bit value so the
    // modulo reduction and duration saturation get hit.
    function automatic logic [LANE_W-1:0] pick_lane(input int unsigned hi);
        if ($urandom_range(0, 4) == 0) return LANE_W'($urandom);
        return LANE_W'($urandom_range(0, hi));
    endfunction

    // One register-port transaction; valid drops on the following fall.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic load_gait(input logic [CFG_DATA_W-1:0] count,
                             input logic [CFG_DATA_W-1:0] ticks,
                             input logic [CFG_DATA_W-1:0] offs,
                             input logic [CFG_DATA_W-1:0] durs,
                             input logic [CFG_DATA_W-1:0] stime);
        write_reg(CFG_SEGMENT_COUNT, count);
        write_reg(CFG_TICKS_PER_SEGMENT, ticks);
        write_reg(CFG_LEG_OFFSETS, offs);
        write_reg(CFG_LEG_DURATIONS, durs);
        write_reg(CFG_SEGMENT_TIME, stime);
    endtask

    // Offer one iteration count, wait for the transaction, then maybe idle.
    // With no gap valid simply stays high into the next offer.
    task automatic send_iteration(input logic [ITER_W-1:0] value, input bit steady);
        int r, gap;
        @(negedge clk);
        in_ch.valid           = 1'b1;
        in_ch.iteration_count = value;
        do @(posedge clk); while (!in_ch.ready);
        if (!steady) begin
            r = $urandom_range(0, 99);
            if (r < 60)      gap = 0;
            else if (r < 90) gap = $urandom_range(1, 4);
            else             gap = $urandom_range(15, 80);
            if (gap > 0) begin
                @(negedge clk);
                in_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Sender stops until every predicted row has come back; the block is
    // idle afterwards, so the registers may be rewritten.
    task automatic drain_rows();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (rows_outstanding != 0) @(negedge clk);
    endtask

    // Sink pacing: bursts of ready, short stalls mostly, a few long ones,
    // an occasional long burst with no stall, and one long hold-off on request.
    initial begin : sink_pacer
        int on_len, off_len, r;
        out_ch.ready = 1'b0;
        forever begin
            if (hold_sink) begin
                @(negedge clk);
                out_ch.ready = 1'b0;
                repeat (SINK_HOLD) @(negedge clk);
                hold_sink = 1'b0;
            end
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 8);
            r = $urandom_range(0, 99);
            if (r < 30)      off_len = 0;
            else if (r < 85) off_len = $urandom_range(1, 3);
            else             off_len = $urandom_range(10, 40);
            repeat (on_len) begin
                @(negedge clk);
                out_ch.ready = 1'b1;
            end
            repeat (off_len) begin
                @(negedge clk);
                out_ch.ready = 1'b0;
            end
        end
    end

    initial begin : stimulus
        int                  r;
        int unsigned         n_eff, t_eff, period;
        logic [CFG_DATA_W-1:0] count, ticks, offs, durs, stime;
        logic [ITER_W-1:0]   base, iter;
        bit                  steady;

        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_SEGMENT_COUNT;
        cfg_ch.data           = '0;
        in_ch.valid           = 1'b0;
        in_ch.iteration_count = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // Reset settings: 10 segments, 1 tick, all durations 0, so stance
        // windows are empty and swing covers the whole cycle.
        send_iteration(32'h0000_0000, 1'b0);
        send_iteration(32'hFFFF_FFFF, 1'b0);
        send_iteration(32'd7, 1'b0);

        // Zero segment count and zero ticks, both taken as 1; every offset
        // reduces to 0 and every duration saturates to the one segment, so
        // the swing window is empty. Upper data bits set everywhere.
        drain_rows();
        load_gait(32'hFFFF_FFC0, 32'hFFFF_FC00, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_iteration(32'h0000_0000, 1'b0);
        send_iteration(32'hFFFF_FFFF, 1'b0);

        // Segment count above limit (saturates to 32 rows), largest ticks,
        // offsets past the cycle, durations of full cycle, zero, partial and over.
        drain_rows();
        load_gait(32'd63, 32'd1023, 32'h00FF_FFFF, {8'h00, pack_lanes(6'd32, 6'd0, 6'd17, 6'd63)},
                  32'hFFFF_FFFF);
        send_iteration(32'h0000_0000, 1'b0);
        send_iteration(32'hFFFF_FFFF, 1'b0);
        send_iteration(32'd32735, 1'b0);   // last tick of the cycle
        send_iteration(32'd32736, 1'b0);   // wraps to the start
        send_iteration(32'd31713, 1'b0);   // start of the last segment

        // Trot-like pattern on a short cycle; two offsets wrap. Iteration 6
        // lands exactly on the end of leg 0's stance window (full 0x8000).
        drain_rows();
        load_gait(32'd4, 32'd3, {8'h00, pack_lanes(6'd4, 6'd1, 6'd6, 6'd3)},
                  {8'h00, pack_lanes(6'd2, 6'd2, 6'd2, 6'd2)}, 32'h0000_8000);
        send_iteration(32'd0, 1'b1);
        send_iteration(32'd5, 1'b1);
        send_iteration(32'd6, 1'b1);
        send_iteration(32'd7, 1'b1);
        send_iteration(32'd11, 1'b1);
        send_iteration(32'd12, 1'b1);

        // Full 32-segment cycle, one tick each, mixed durations.
        drain_rows();
        load_gait(32'd32, 32'd1, 32'h0000_0000, {8'h00, pack_lanes(6'd31, 6'd1, 6'd16, 6'd0)},
                  32'h0001_0000);
        send_iteration(32'd31, 1'b0);
        send_iteration(32'd32, 1'b0);

        // --- random part: one setting per phase ---
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_rows();

            r = $urandom_range(0, 9);
            if (r == 0)      count = 32'd0;
            else if (r == 1) count = $urandom;
            else if (r == 2) count = 32'd32;
            else if (r == 3) count = 32'd63;
            else             count = $urandom_range(1, 12);
            n_eff = count[SEG_W-1:0];
            if (n_eff == 0) n_eff = 1;
            if (n_eff > SEG_LIMIT) n_eff = SEG_LIMIT;

            r = $urandom_range(0, 9);
            if (r == 0)      ticks = 32'd0;
            else if (r == 1) ticks = 32'd1023;
            else if (r == 2) ticks = $urandom;
            else             ticks = $urandom_range(1, 6);
            t_eff = ticks[TICK_W-1:0];
            if (t_eff == 0) t_eff = 1;
            period = n_eff * t_eff;

            offs  = {8'($urandom), pack_lanes(pick_lane(n_eff - 1), pick_lane(n_eff - 1),
                                              pick_lane(n_eff - 1), pick_lane(n_eff - 1))};
            durs  = {8'($urandom), pack_lanes(pick_lane(n_eff), pick_lane(n_eff),
                                              pick_lane(n_eff), pick_lane(n_eff))};
            stime = $urandom;
            load_gait(count, ticks, offs, durs, stime);

            // Long sink hold-off while items keep coming: the block stays busy with
            // its rows and must stall the iteration channel.
            if (ph == 2) hold_sink = 1'b1;
            steady = (ph == 5);
            base   = $urandom;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 4 && k == PHASE_ITEMS / 2) drain_rows();
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    // control loop style: counter creeping forward
                    base = base + $urandom_range(1, 3);
                    iter = base;
                end else if (r < 65) begin
                    // just around a cycle boundary
                    iter = $urandom_range(0, 100000) * period + $urandom_range(0, 2) - 1;
                end else if (r < 75) begin
                    iter = $urandom_range(0, 2 * period);
                end else begin
                    iter = $urandom;
                end
                send_iteration(iter, steady);
            end
        end

        drain_rows();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && rows_outstanding == 0) begin
            $display("legged_gait_phase_scheduler test passed");
        end else begin
            $display("legged_gait_phase_scheduler test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
